// ===== src/tmt_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// Turmite package
// Shared widths, codes, payload structs and reset helpers for the multi-ant
// turmite block.
// -----------------------------------------------------------------------------
package tmt_pkg;

   localparam int GRID_WIDTH  = 256;
   localparam int GRID_HEIGHT = 256;
   localparam int GRID_DEPTH  = GRID_WIDTH * GRID_HEIGHT;
   localparam int MAX_STATES  = 16;

   localparam int COORD_W   = 8;
   localparam int ADDR_W    = 16;
   localparam int CELL_W    = 4;
   localparam int CNT_W     = 5;
   localparam int RULE_W    = 32;
   localparam int CSR_IDX_W = 8;

   localparam int ANT_COL_SPACING = 260;
   localparam int ANT_ROW_SPACING = 5;

   localparam logic [RULE_W-1:0] RULE_TABLE_RESET = 32'd68;
   localparam logic [CNT_W-1:0]  NUM_STATES_RESET = 5'd4;

   typedef enum logic {
      REQ_STEP  = 1'b0,
      REQ_PLACE = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      TURN_RIGHT   = 2'd0,
      TURN_LEFT    = 2'd1,
      TURN_FORWARD = 2'd2,
      TURN_BACK    = 2'd3
   } turn_code_type;

   typedef enum logic [1:0] {
      HEAD_UP    = 2'd0,
      HEAD_RIGHT = 2'd1,
      HEAD_DOWN  = 2'd2,
      HEAD_LEFT  = 2'd3
   } heading_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RULE_TABLE = 8'd0,
      CSR_NUM_STATES = 8'd1
   } csr_index_type;

   typedef struct packed {
      logic               req_type;
      logic               ant_index;
      logic [COORD_W-1:0] place_x;
      logic [COORD_W-1:0] place_y;
      logic [1:0]         place_dir;
   } tmt_req_type;

   typedef struct packed {
      logic               ant_id;
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
      logic [CELL_W-1:0]  cell_state;
      logic [COORD_W-1:0] ant_x;
      logic [COORD_W-1:0] ant_y;
      logic [1:0]         ant_heading;
   } tmt_rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] reg_index;
      logic [RULE_W-1:0]    wr_data;
   } tmt_csr_type;

   typedef struct packed {
      logic [RULE_W-1:0] rule_table;
      logic [CNT_W-1:0]  n_states;   // clamped to 1..MAX_STATES
   } tmt_cfg_type;

   function automatic logic [COORD_W-1:0] reset_column(input int unsigned idx);
      int unsigned back;
      back = (ANT_COL_SPACING * idx) % GRID_WIDTH;
      return COORD_W'((GRID_WIDTH / 2 + GRID_WIDTH - back) % GRID_WIDTH);
   endfunction

   function automatic logic [COORD_W-1:0] reset_row(input int unsigned idx);
      int unsigned back;
      back = (ANT_ROW_SPACING * idx) % GRID_HEIGHT;
      return COORD_W'((GRID_HEIGHT / 2 + GRID_HEIGHT - back) % GRID_HEIGHT);
   endfunction

   function automatic logic [1:0] reset_heading(input int unsigned idx);
      return 2'((2 * idx) % 4);
   endfunction

endpackage
`default_nettype wire

// ===== src/tmt_chan_if.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// Turmite channel interface
// Valid/ready channel carrying one payload struct per transfer.
// -----------------------------------------------------------------------------
interface tmt_chan_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface
`default_nettype wire

// ===== src/tmt_ram.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// Turmite generic RAM
// One write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module tmt_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== src/tmt_cmpsub.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// Turmite compare-subtract unit
// Compares opa against opb and gives opa - opb; shared by the modulo steps
// and the next-state wrap.
// -----------------------------------------------------------------------------
module tmt_cmpsub #(
   parameter int WIDTH = 5
) (
   input  wire logic [WIDTH-1:0] opa,
   input  wire logic [WIDTH-1:0] opb,
   output logic                  ge,
   output logic      [WIDTH-1:0] diff
);

   logic [WIDTH:0] wide_diff;

   assign wide_diff = {1'b0, opa} - {1'b0, opb};
   assign ge        = ~wide_diff[WIDTH];
   assign diff      = wide_diff[WIDTH-1:0];

endmodule
`default_nettype wire

// ===== src/tmt_csr.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// Turmite configuration registers
// Rule table and state count, with the state count clamped to its legal range.
// -----------------------------------------------------------------------------
module tmt_csr (
   input  wire logic         clock,
   input  wire logic         reset,
   tmt_chan_if.sink          csr_chan,
   output tmt_pkg::tmt_cfg_type cfg
);

   logic [tmt_pkg::RULE_W-1:0] rule_ff;
   logic [tmt_pkg::RULE_W-1:0] rule_in;
   logic [tmt_pkg::CNT_W-1:0]  num_ff;
   logic [tmt_pkg::CNT_W-1:0]  num_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      rule_in = rule_ff;
      num_in  = num_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.payload.reg_index)
            tmt_pkg::CSR_RULE_TABLE: rule_in = csr_chan.payload.wr_data;
            tmt_pkg::CSR_NUM_STATES: num_in  = csr_chan.payload.wr_data[tmt_pkg::CNT_W-1:0];
            default: ;   // unknown index, transfer dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff <= tmt_pkg::RULE_TABLE_RESET;
         num_ff  <= tmt_pkg::NUM_STATES_RESET;
      end else begin
         rule_ff <= rule_in;
         num_ff  <= num_in;
      end
   end

   always_comb begin
      cfg.rule_table = rule_ff;
      priority if (num_ff == '0) begin
         cfg.n_states = tmt_pkg::CNT_W'(1);
      end else if (num_ff > tmt_pkg::CNT_W'(tmt_pkg::MAX_STATES)) begin
         cfg.n_states = tmt_pkg::CNT_W'(tmt_pkg::MAX_STATES);
      end else begin
         cfg.n_states = num_ff;
      end
   end

endmodule
`default_nettype wire

// ===== src/multi_ant_turmite_step.sv =====
`default_nettype none
// Place item: taken in IDLE, then committed in UPDATE once the result register is free.
// Step item: IDLE, LOAD, REDUCE, UPDATE in turn; REDUCE runs the k subtractions the
//   compare-subtract unit needs to reduce the cell state modulo the state count (0..15).
// One item at a time; the result register lets the next item in while it waits.
// Reset runs a clearing pass over all 65536 grid RAM cells before the first
//   item is taken; configuration transfers are taken throughout.
// -----------------------------------------------------------------------------
// Multi-ant turmite step
// Sequencer, ant registers and grid RAM for several turmites on a torus.
// -----------------------------------------------------------------------------
module multi_ant_turmite_step #(
   parameter int NUM_ANTS = 2
) (
   input  wire logic clock,
   input  wire logic reset,
   tmt_chan_if.sink   req_chan,
   tmt_chan_if.source rsp_chan,
   tmt_chan_if.sink   csr_chan
);

   localparam int AntIdxW = (NUM_ANTS > 1) ? $clog2(NUM_ANTS) : 1;
   localparam int CoordW  = tmt_pkg::COORD_W;
   localparam int CellW   = tmt_pkg::CELL_W;
   localparam int CntW    = tmt_pkg::CNT_W;
   localparam int AddrW   = tmt_pkg::ADDR_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_REDUCE,
      ST_UPDATE
   } state_type;

   state_type                state_ff, state_in;
   logic [AddrW-1:0]         clr_addr_ff, clr_addr_in;
   tmt_pkg::tmt_req_type     item_ff, item_in;
   logic [AntIdxW-1:0]       sel_ff, sel_in;
   logic [CellW-1:0]         rem_ff, rem_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   tmt_pkg::tmt_rsp_type     rsp_ff, rsp_in;
   logic [CoordW-1:0]        ant_col_ff [NUM_ANTS];
   logic [CoordW-1:0]        ant_col_in [NUM_ANTS];
   logic [CoordW-1:0]        ant_row_ff [NUM_ANTS];
   logic [CoordW-1:0]        ant_row_in [NUM_ANTS];
   logic [1:0]               ant_dir_ff [NUM_ANTS];
   logic [1:0]               ant_dir_in [NUM_ANTS];

   tmt_pkg::tmt_cfg_type     cfg;
   logic [AntIdxW-1:0]       req_sel;
   logic [CoordW-1:0]        cur_x, cur_y, next_x, next_y;
   logic [1:0]               cur_dir, next_dir, turn_delta;
   logic [1:0]               turn_code;
   logic [CntW-1:0]          cmp_a, cmp_diff;
   logic                     cmp_ge;
   logic [CellW-1:0]         next_cell;
   logic                     slot_free;

   logic                     ram_wr_en;
   logic [AddrW-1:0]         ram_wr_addr;
   logic [CellW-1:0]         ram_wr_data;
   logic [AddrW-1:0]         ram_rd_addr;
   logic [CellW-1:0]         ram_rd_data;

   tmt_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   tmt_ram #(
      .WIDTH (CellW),
      .DEPTH (tmt_pkg::GRID_DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // modulo steps in REDUCE, wrap of state + 1 in UPDATE
   assign cmp_a = (state_ff == ST_UPDATE) ? ({1'b0, rem_ff} + CntW'(1)) : {1'b0, rem_ff};

   tmt_cmpsub #(
      .WIDTH (CntW)
   ) u_cmp (
      .opa  (cmp_a),
      .opb  (cfg.n_states),
      .ge   (cmp_ge),
      .diff (cmp_diff)
   );

   assign req_sel     = (NUM_ANTS > 1) ? AntIdxW'(req_chan.payload.ant_index) : '0;
   // read issued as the item is taken, data lands in LOAD
   assign ram_rd_addr = {ant_row_ff[req_sel], ant_col_ff[req_sel]};

   assign cur_x     = ant_col_ff[sel_ff];
   assign cur_y     = ant_row_ff[sel_ff];
   assign cur_dir   = ant_dir_ff[sel_ff];
   assign turn_code = cfg.rule_table[{rem_ff, 1'b0} +: 2];
   assign next_cell = cmp_ge ? cmp_diff[CellW-1:0] : cmp_a[CellW-1:0];
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      unique case (turn_code)
         tmt_pkg::TURN_RIGHT:   turn_delta = 2'd1;
         tmt_pkg::TURN_LEFT:    turn_delta = 2'd3;
         tmt_pkg::TURN_FORWARD: turn_delta = 2'd0;
         tmt_pkg::TURN_BACK:    turn_delta = 2'd2;
         default:               turn_delta = 2'd0;
      endcase
      next_dir = cur_dir + turn_delta;
      next_x   = cur_x;
      next_y   = cur_y;
      // grid edges are powers of two, so the wrap is the natural overflow
      unique case (next_dir)
         tmt_pkg::HEAD_UP:    next_y = cur_y - CoordW'(1);
         tmt_pkg::HEAD_RIGHT: next_x = cur_x + CoordW'(1);
         tmt_pkg::HEAD_DOWN:  next_y = cur_y + CoordW'(1);
         tmt_pkg::HEAD_LEFT:  next_x = cur_x - CoordW'(1);
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      item_in      = item_ff;
      sel_in       = sel_ff;
      rem_in       = rem_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      ant_col_in   = ant_col_ff;
      ant_row_in   = ant_row_ff;
      ant_dir_in   = ant_dir_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = clr_addr_ff;
      ram_wr_data  = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            clr_addr_in = clr_addr_ff + AddrW'(1);
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               item_in  = req_chan.payload;
               sel_in   = req_sel;
               state_in = (req_chan.payload.req_type == tmt_pkg::REQ_PLACE) ? ST_UPDATE
                                                                             : ST_LOAD;
            end
         end
         ST_LOAD: begin
            rem_in   = ram_rd_data;
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (cmp_ge) begin
               rem_in = cmp_diff[CellW-1:0];
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // nothing commits until the result register can take the result
            if (slot_free) begin
               state_in         = ST_IDLE;
               rsp_valid_in     = 1'b1;
               rsp_in.ant_id    = sel_ff[0];
               if (item_ff.req_type == tmt_pkg::REQ_PLACE) begin
                  ant_col_in[sel_ff] = item_ff.place_x;
                  ant_row_in[sel_ff] = item_ff.place_y;
                  ant_dir_in[sel_ff] = item_ff.place_dir;
                  rsp_in.cell_x      = '0;
                  rsp_in.cell_y      = '0;
                  rsp_in.cell_state  = '0;
                  rsp_in.ant_x       = item_ff.place_x;
                  rsp_in.ant_y       = item_ff.place_y;
                  rsp_in.ant_heading = item_ff.place_dir;
               end else begin
                  ram_wr_en          = 1'b1;
                  ram_wr_addr        = {cur_y, cur_x};
                  ram_wr_data        = next_cell;
                  ant_col_in[sel_ff] = next_x;
                  ant_row_in[sel_ff] = next_y;
                  ant_dir_in[sel_ff] = next_dir;
                  rsp_in.cell_x      = cur_x;
                  rsp_in.cell_y      = cur_y;
                  rsp_in.cell_state  = next_cell;
                  rsp_in.ant_x       = next_x;
                  rsp_in.ant_y       = next_y;
                  rsp_in.ant_heading = next_dir;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      sel_ff  <= sel_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_ANTS; i++) begin
            ant_col_ff[i] <= tmt_pkg::reset_column(i);
            ant_row_ff[i] <= tmt_pkg::reset_row(i);
            ant_dir_ff[i] <= tmt_pkg::reset_heading(i);
         end
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         ant_col_ff   <= ant_col_in;
         ant_row_ff   <= ant_row_in;
         ant_dir_ff   <= ant_dir_in;
      end
   end

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // a new result only ever follows an update cycle
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("result raised without an update cycle");

   // the modulo loop has finished before the cell is rewritten
   a_rem_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) && (item_ff.req_type == tmt_pkg::REQ_STEP)
         |-> ({1'b0, rem_ff} < cfg.n_states))
      else $error("cell state not reduced below state count");

   // the grid is never written while waiting for an item
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_wr_en)
      else $error("grid write while idle");

   // a transfer in always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff != ST_IDLE))
      else $error("item taken but sequencer stayed idle");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Turmite step testbench
// Feeds the multi-ant turmite with a short scripted sequence of placements,
// steps and register writes, then long randomised runs under several rule
// tables, state counts and flow-control patterns. A cycle-free model of the
// ants and grid, or a script row, gives each result, compared field by field.
// -----------------------------------------------------------------------------
module tb;
   import tmt_pkg::*;

   localparam int NUM_ANTS       = 2;
   localparam int QUIET_LIMIT    = 200_000;   // covers the grid clearing pass
   localparam int PHASE_COUNT    = 12;
   localparam int PHASE_ITEMS    = 136;
   localparam int SETTLE_CYCLES  = 40;
   localparam int PRINT_CAP      = 200;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_IDX   = 8'hFF;
   localparam logic [COORD_W-1:0]   FILLER        = 8'h5A;

   typedef enum int {PACE_FULL, PACE_SEND, PACE_RECV, PACE_BOTH} pace_type;

   typedef struct {
      bit                   cfg_write;
      tmt_req_type          item;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [RULE_W-1:0]    reg_val;
      bit                   hand;
      tmt_rsp_type          want;
   } script_row_type;

   logic clock;
   logic reset;

   tmt_chan_if #(.payload_type(tmt_req_type)) req_if ();
   tmt_chan_if #(.payload_type(tmt_rsp_type)) rsp_if ();
   tmt_chan_if #(.payload_type(tmt_csr_type)) csr_if ();

   multi_ant_turmite_step #(.NUM_ANTS(NUM_ANTS)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // model of the ants and the grid
   logic [CELL_W-1:0]  trail_mem [GRID_DEPTH];
   logic [COORD_W-1:0] ant_col [NUM_ANTS];
   logic [COORD_W-1:0] ant_row [NUM_ANTS];
   logic [1:0]         ant_dir [NUM_ANTS];
   logic [RULE_W-1:0]  turn_rules;
   logic [CNT_W-1:0]   state_count;

   tmt_rsp_type    pending_moves [$];
   script_row_type script_q [$];
   tmt_rsp_type    predicted;
   bit             hand_check;
   tmt_rsp_type    hand_rsp;
   int             err_count;
   int             quiet_cycles;
   int             send_gap_pct;
   int             recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic tmt_rsp_type turmite_advance(input tmt_req_type r);
      tmt_rsp_type        o;
      int unsigned        n;
      int unsigned        s;
      int unsigned        nxt;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [1:0]         d;
      logic [ADDR_W-1:0]  addr;
      o = '0;
      o.ant_id = r.ant_index;
      if (r.req_type == REQ_PLACE) begin
         ant_col[r.ant_index] = r.place_x;
         ant_row[r.ant_index] = r.place_y;
         ant_dir[r.ant_index] = r.place_dir;
      end else begin
         n = (state_count == 0) ? 1 : (state_count > MAX_STATES) ? MAX_STATES : state_count;
         x = ant_col[r.ant_index];
         y = ant_row[r.ant_index];
         d = ant_dir[r.ant_index];
         addr = {y, x};
         s = trail_mem[addr] % n;
         case (turn_code_type'(turn_rules[2*s +: 2]))
            TURN_RIGHT: d = d + 2'd1;
            TURN_LEFT:  d = d - 2'd1;
            TURN_BACK:  d = d + 2'd2;
            default:    ;
         endcase
         nxt = (s + 1) % n;
         trail_mem[addr] = CELL_W'(nxt);
         o.cell_x = x;
         o.cell_y = y;
         o.cell_state = CELL_W'(nxt);
         // 256 x 256 torus: plain 8-bit wrap
         case (heading_type'(d))
            HEAD_UP:    y = y - 1'b1;
            HEAD_RIGHT: x = x + 1'b1;
            HEAD_DOWN:  y = y + 1'b1;
            default:    x = x - 1'b1;
         endcase
         ant_col[r.ant_index] = x;
         ant_row[r.ant_index] = y;
         ant_dir[r.ant_index] = d;
      end
      o.ant_x = ant_col[r.ant_index];
      o.ant_y = ant_row[r.ant_index];
      o.ant_heading = ant_dir[r.ant_index];
      return o;
   endfunction

   task automatic note_error(input string msg);
      if (err_count < PRINT_CAP)
         $display("%0t tb: mismatch: %s", $realtime, msg);
      err_count++;
   endtask

   task automatic check_move(input tmt_rsp_type got);
      tmt_rsp_type want;
      if (pending_moves.size() == 0) begin
         note_error($sformatf("result %h with nothing outstanding", got));
         return;
      end
      want = pending_moves.pop_front();
      if (got.ant_id !== want.ant_id)
         note_error($sformatf("ant_id %0d, want %0d", got.ant_id, want.ant_id));
      if (got.cell_x !== want.cell_x)
         note_error($sformatf("cell_x %0d, want %0d", got.cell_x, want.cell_x));
      if (got.cell_y !== want.cell_y)
         note_error($sformatf("cell_y %0d, want %0d", got.cell_y, want.cell_y));
      if (got.cell_state !== want.cell_state)
         note_error($sformatf("cell_state %0d, want %0d", got.cell_state, want.cell_state));
      if (got.ant_x !== want.ant_x)
         note_error($sformatf("ant_x %0d, want %0d", got.ant_x, want.ant_x));
      if (got.ant_y !== want.ant_y)
         note_error($sformatf("ant_y %0d, want %0d", got.ant_y, want.ant_y));
      if (got.ant_heading !== want.ant_heading)
         note_error($sformatf("ant_heading %0d, want %0d", got.ant_heading, want.ant_heading));
   endtask

   // monitor: result first, so a stray result never consumes a fresh prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready)
            check_move(rsp_if.payload);
         if (csr_if.valid && csr_if.ready) begin
            if (csr_if.payload.reg_index == CSR_RULE_TABLE)
               turn_rules = csr_if.payload.wr_data;
            else if (csr_if.payload.reg_index == CSR_NUM_STATES)
               state_count = csr_if.payload.wr_data[CNT_W-1:0];
         end
         if (req_if.valid && req_if.ready) begin
            predicted = turmite_advance(req_if.payload);
            pending_moves.push_back(hand_check ? hand_rsp : predicted);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

   task automatic send_item(input tmt_req_type r, input bit hand, input tmt_rsp_type want);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      hand_check = hand;
      hand_rsp = want;
      req_if.payload <= r;
      req_if.valid <= 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // leaves valid high; the caller drops it once the batch of writes is done
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [RULE_W-1:0] val);
      csr_if.payload <= tmt_csr_type'{reg_index: idx, wr_data: val};
      csr_if.valid <= 1'b1;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_moves;
      while (pending_moves.size() != 0) @(negedge clock);
   endtask

   function automatic void plan_item(input req_kind_type k, input logic ant,
                                     input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                     input logic [1:0] dir, input bit hand,
                                     input tmt_rsp_type want);
      script_row_type row;
      row = '{default: '0};
      row.item = tmt_req_type'{k, ant, x, y, dir};
      row.hand = hand;
      row.want = want;
      script_q.push_back(row);
   endfunction

   function automatic void plan_write(input logic [CSR_IDX_W-1:0] idx,
                                      input logic [RULE_W-1:0] val);
      script_row_type row;
      row = '{default: '0};
      row.cfg_write = 1'b1;
      row.reg_idx = idx;
      row.reg_val = val;
      script_q.push_back(row);
   endfunction

   function automatic tmt_req_type random_item;
      tmt_req_type r;
      r.req_type = ($urandom_range(0, 99) < 12) ? REQ_PLACE : REQ_STEP;
      r.ant_index = 1'($urandom_range(0, 1));
      // half the placements land near the centre so trails get revisited
      if ($urandom_range(0, 1)) begin
         r.place_x = COORD_W'($urandom_range(112, 143));
         r.place_y = COORD_W'($urandom_range(112, 143));
      end else begin
         r.place_x = COORD_W'($urandom_range(0, 255));
         r.place_y = COORD_W'($urandom_range(0, 255));
      end
      r.place_dir = 2'($urandom_range(0, 3));
      return r;
   endfunction

   initial begin
      logic [RULE_W-1:0] rule_val;
      logic [RULE_W-1:0] count_val;
      pace_type          pace;

      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      csr_if.valid = 1'b0;
      csr_if.payload = '0;
      rsp_if.ready = 1'b0;
      err_count = 0;
      quiet_cycles = 0;
      send_gap_pct = 0;
      recv_stall_pct = 0;
      hand_check = 1'b0;
      hand_rsp = '0;

      foreach (trail_mem[i]) trail_mem[i] = '0;
      for (int i = 0; i < NUM_ANTS; i++) begin
         ant_col[i] = COORD_W'(GRID_WIDTH / 2 - ANT_COL_SPACING * i);
         ant_row[i] = COORD_W'(GRID_HEIGHT / 2 - ANT_ROW_SPACING * i);
         ant_dir[i] = 2'(2 * i);
      end
      turn_rules = RULE_TABLE_RESET;
      state_count = NUM_STATES_RESET;

      // reset rule table: R,L,R,L
      plan_item(REQ_STEP, 1'b0, FILLER, FILLER, HEAD_LEFT, 1'b1,
                tmt_rsp_type'{1'b0, 8'd128, 8'd128, 4'd1, 8'd129, 8'd128, HEAD_RIGHT});
      plan_item(REQ_STEP, 1'b1, FILLER, FILLER, HEAD_LEFT, 1'b1,
                tmt_rsp_type'{1'b1, 8'd124, 8'd123, 4'd1, 8'd123, 8'd123, HEAD_LEFT});
      plan_item(REQ_PLACE, 1'b0, 8'd255, 8'd255, HEAD_RIGHT, 1'b1,
                tmt_rsp_type'{1'b0, 8'd0, 8'd0, 4'd0, 8'd255, 8'd255, HEAD_RIGHT});
      plan_item(REQ_STEP, 1'b0, FILLER, FILLER, HEAD_UP, 1'b1,
                tmt_rsp_type'{1'b0, 8'd255, 8'd255, 4'd1, 8'd255, 8'd0, HEAD_DOWN});
      plan_item(REQ_PLACE, 1'b1, 8'd0, 8'd0, HEAD_LEFT, 1'b1,
                tmt_rsp_type'{1'b1, 8'd0, 8'd0, 4'd0, 8'd0, 8'd0, HEAD_LEFT});
      plan_item(REQ_STEP, 1'b1, FILLER, FILLER, HEAD_UP, 1'b1,
                tmt_rsp_type'{1'b1, 8'd0, 8'd0, 4'd1, 8'd0, 8'd255, HEAD_UP});
      plan_item(REQ_PLACE, 1'b0, 8'd128, 8'd128, HEAD_UP, 1'b1,
                tmt_rsp_type'{1'b0, 8'd0, 8'd0, 4'd0, 8'd128, 8'd128, HEAD_UP});
      plan_item(REQ_STEP, 1'b0, FILLER, FILLER, HEAD_UP, 1'b1,
                tmt_rsp_type'{1'b0, 8'd128, 8'd128, 4'd2, 8'd127, 8'd128, HEAD_LEFT});
      // zero state count acts as one; straight on
      plan_write(CSR_NUM_STATES, 32'd0);
      plan_write(CSR_RULE_TABLE, 32'h0000_0002);
      plan_item(REQ_STEP, 1'b0, FILLER, FILLER, HEAD_UP, 1'b0, '0);
      plan_item(REQ_STEP, 1'b0, FILLER, FILLER, HEAD_UP, 1'b0, '0);
      // U-turn, bouncing over a cell that holds a state beyond the count
      plan_write(CSR_RULE_TABLE, 32'h0000_0003);
      plan_item(REQ_STEP, 1'b1, FILLER, FILLER, HEAD_UP, 1'b0, '0);
      plan_item(REQ_STEP, 1'b1, FILLER, FILLER, HEAD_UP, 1'b0, '0);
      // oversize count clamps to the maximum; R,L,F,U repeating
      plan_write(CSR_NUM_STATES, 32'd31);
      plan_write(CSR_RULE_TABLE, 32'hE4E4_E4E4);
      plan_item(REQ_PLACE, 1'b0, 8'd128, 8'd128, HEAD_DOWN, 1'b0, '0);
      plan_item(REQ_STEP, 1'b0, FILLER, FILLER, HEAD_UP, 1'b0, '0);
      plan_item(REQ_STEP, 1'b0, FILLER, FILLER, HEAD_UP, 1'b0, '0);
      plan_item(REQ_STEP, 1'b0, FILLER, FILLER, HEAD_UP, 1'b0, '0);
      // writes to unmapped indexes must leave both registers alone
      plan_write(CSR_SPARE_IDX, 32'd0);
      plan_write(CSR_TOP_IDX, 32'd1);
      plan_item(REQ_STEP, 1'b1, FILLER, FILLER, HEAD_UP, 1'b0, '0);
      plan_item(REQ_STEP, 1'b0, FILLER, FILLER, HEAD_UP, 1'b0, '0);
      plan_write(CSR_NUM_STATES, 32'd16);
      plan_write(CSR_RULE_TABLE, 32'hFFFF_FFFF);
      plan_item(REQ_STEP, 1'b0, FILLER, FILLER, HEAD_UP, 1'b0, '0);
      plan_item(REQ_STEP, 1'b1, FILLER, FILLER, HEAD_UP, 1'b0, '0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script_q[i]) begin
         if (script_q[i].cfg_write) begin
            req_if.valid <= 1'b0;
            drain_moves();
            write_reg(script_q[i].reg_idx, script_q[i].reg_val);
         end else begin
            csr_if.valid <= 1'b0;
            send_item(script_q[i].item, script_q[i].hand, script_q[i].want);
         end
      end

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         req_if.valid <= 1'b0;
         drain_moves();
         case (ph)
            0: begin rule_val = 32'h0000_0000; count_val = 32'd1;  end
            1: begin rule_val = 32'hFFFF_FFFF; count_val = 32'd16; end
            2: begin rule_val = 32'h5555_5555; count_val = 32'd31; end
            3: begin rule_val = 32'hAAAA_AAAA; count_val = 32'd0;  end
            4: begin rule_val = 32'h0000_0044; count_val = 32'd17; end
            default: begin
               rule_val = $urandom();
               count_val = $urandom_range(0, 31);
            end
         endcase
         write_reg(CSR_RULE_TABLE, rule_val);
         write_reg(CSR_NUM_STATES, count_val);
         csr_if.valid <= 1'b0;
         pace = pace_type'(ph % 4);
         case (pace)
            PACE_SEND: begin send_gap_pct = 84; recv_stall_pct = 0;  end
            PACE_RECV: begin send_gap_pct = 0;  recv_stall_pct = 84; end
            PACE_BOTH: begin send_gap_pct = 24; recv_stall_pct = 24; end
            default:   begin send_gap_pct = 0;  recv_stall_pct = 0;  end
         endcase
         repeat (PHASE_ITEMS) send_item(random_item(), 1'b0, '0);
      end

      req_if.valid <= 1'b0;
      drain_moves();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_moves.size() != 0)
         note_error($sformatf("%0d results never arrived", pending_moves.size()));
      if (err_count == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
